>>> rtl/core/rfft_pkg.sv
// Shared types, codes and helpers of the radix-2 real/complex FFT engine.
`timescale 1ns / 1ps
`default_nettype none

package rfft_pkg;

   localparam int MAX_WORDS_DEFAULT    = 4096;
   localparam int TWIDDLE_BITS_DEFAULT = 18;

   localparam int INDEX_W  = 12;
   localparam int SAMPLE_W = 16;
   localparam int WORD_W   = 32;
   localparam int HALF_W   = 33;
   localparam int PROD_W   = 36;
   localparam int SUM_W    = 38;
   localparam int CSR_W    = 4;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam logic [1:0] CSR_DIRECTION  = 2'd0;
   localparam logic [1:0] CSR_REAL_MODE  = 2'd1;
   localparam logic [1:0] CSR_LOG2_WORDS = 2'd2;

   typedef struct packed {
      logic [1:0]                 op;
      logic [INDEX_W-1:0]         word_index;
      logic signed [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic                     result_kind;
      logic signed [WORD_W-1:0] word_out;
   } rsp_type;

   function automatic logic [WORD_W-1:0] sat32(input logic [SUM_W-1:0] v);
      logic [WORD_W-1:0] r;
      if (v[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){1'b0}} ||
          v[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){1'b1}}) begin
         r = v[WORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/rfft_cmul.sv
// Shared complex multiplier: one multiplier used four times per twiddle product.
`timescale 1ns / 1ps
`default_nettype none

module rfft_cmul
   import rfft_pkg::*;
#(
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic signed [HALF_W-1:0]       x,
   input  wire logic signed [HALF_W-1:0]       y,
   input  wire logic signed [TWIDDLE_BITS-1:0] wr,
   input  wire logic signed [TWIDDLE_BITS-1:0] wi,
   output logic                                done,
   output logic signed [PROD_W-1:0]            pr,
   output logic signed [PROD_W-1:0]            pi
);

   localparam int MW = HALF_W + TWIDDLE_BITS;
   localparam int F  = TWIDDLE_BITS - 2;
   localparam logic signed [MW:0] RND = (MW+1)'(1) << (F - 1);

   logic [2:0]                  step_ff;
   logic                        done_ff;
   logic signed [MW-1:0]        mul_ff;
   logic signed [MW-1:0]        acc_ff;
   logic signed [PROD_W-1:0]    pr_ff;
   logic signed [PROD_W-1:0]    pi_ff;
   logic signed [HALF_W-1:0]    op_a;
   logic signed [TWIDDLE_BITS-1:0] op_b;
   logic signed [MW:0]          diff;
   logic signed [MW:0]          summ;
   logic signed [MW:0]          rdiff;
   logic signed [MW:0]          rsum;

   always_comb begin
      case (step_ff)
         3'd0: begin
            op_a = x;
            op_b = wr;
         end
         3'd1: begin
            op_a = y;
            op_b = wi;
         end
         3'd2: begin
            op_a = y;
            op_b = wr;
         end
         default: begin
            op_a = x;
            op_b = wi;
         end
      endcase
      diff  = {acc_ff[MW-1], acc_ff} - {mul_ff[MW-1], mul_ff};
      summ  = {acc_ff[MW-1], acc_ff} + {mul_ff[MW-1], mul_ff};
      rdiff = (diff + RND) >>> F;
      rsum  = (summ + RND) >>> F;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= 3'd1;
         end else if (step_ff != 3'd0) begin
            if (step_ff == 3'd4) begin
               step_ff <= 3'd0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= op_a * op_b;
      case (step_ff)
         3'd1: acc_ff <= mul_ff;
         3'd2: pr_ff  <= rdiff[PROD_W-1:0];
         3'd3: acc_ff <= mul_ff;
         3'd4: pi_ff  <= rsum[PROD_W-1:0];
         default: ;
      endcase
   end

   assign done = done_ff;
   assign pr   = pr_ff;
   assign pi   = pi_ff;

endmodule

`default_nettype wire

>>> rtl/core/radix2_real_complex_fft_top.sv
// Top level of the in-place radix-2 real/complex FFT engine with its word store.
`timescale 1ns / 1ps
`default_nettype none

// A load transaction writes one word in the cycle it is accepted; a read transaction registers
// its word from the store and presents it once any earlier response has been taken. A run
// transaction walks the whole transform over the single-port word store with one shared complex
// multiplier: each bit-reversal swap goes through a compare, the store reads, the store writes
// and an advance, and each index without a swap through the compare and the advance. Each
// butterfly or split step goes through address setup, store read, prepare, multiply, store
// write and advance, preceded by a twiddle table lookup whenever the twiddle changes. No
// transaction is accepted while another is in progress. The store is not cleared at reset;
// words must be loaded before use.
module radix2_real_complex_fft_top
   import rfft_pkg::*;
#(
   parameter int MAX_WORDS    = MAX_WORDS_DEFAULT,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   localparam int AW      = $clog2(MAX_WORDS);
   localparam int QUARTER = MAX_WORDS / 4;
   localparam int QSH     = $clog2(QUARTER);
   localparam int TW_FRAC = TWIDDLE_BITS - 2;
   localparam int TW_SH   = 30 - TW_FRAC;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TAYLOR_DIV [15] = '{
      64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156, 64'sd210, 64'sd272,
      64'sd342, 64'sd420, 64'sd506, 64'sd600, 64'sd702, 64'sd812, 64'sd930
   };

   typedef logic [TWIDDLE_BITS-1:0] rom_type [QUARTER+1];

   function automatic rom_type build_sine();
      rom_type r;
      longint  x;
      longint  term;
      longint  sum;
      longint  val;
      for (int j = 0; j <= QUARTER; j++) begin
         x    = (longint'(j) * HALF_PI_Q30 + longint'(QUARTER / 2)) >>> QSH;
         term = x;
         sum  = x;
         for (int t = 1; t <= 15; t++) begin
            term = (term * x) / ONE_Q30;
            term = (term * x) / ONE_Q30;
            term = -term / TAYLOR_DIV[t - 1];
            sum  = sum + term;
         end
         if (TW_SH > 0) begin
            val = (sum + (64'sd1 <<< (TW_SH - 1))) >>> TW_SH;
         end else begin
            val = sum;
         end
         if (val < 0) begin
            val = 0;
         end
         if (val > (64'sd1 <<< TW_FRAC)) begin
            val = 64'sd1 <<< TW_FRAC;
         end
         r[j] = TWIDDLE_BITS'(val);
      end
      r[0]       = '0;
      r[QUARTER] = TWIDDLE_BITS'(64'sd1 <<< TW_FRAC);
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_sine();

   typedef enum logic [3:0] {
      S_IDLE, S_RDW, S_OUT, S_START, S_BREV, S_TWID, S_SETUP,
      S_READ, S_PREP, S_MUL, S_WRITE, S_NEXT
   } state_type;

   typedef enum logic [1:0] {PH_BREV, PH_BFLY, PH_SPLIT, PH_EDGE} phase_type;

   state_type  state_ff;
   phase_type  phase_ff;
   logic       dir_ff;
   logic       real_ff;
   logic [3:0] l2w_ff;
   logic [4:0] bits_ff;
   logic [4:0] st_ff;
   logic [2:0] cnt_ff;
   logic       cfft_done_ff;
   logic       mul_go_ff;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] k_ff;
   logic [AW-1:0] addr_ff [4];
   logic [WORD_W-1:0] w_ff [4];
   logic signed [HALF_W-1:0] a_ff;
   logic signed [HALF_W-1:0] b_ff;
   logic signed [HALF_W-1:0] x_ff;
   logic signed [HALF_W-1:0] y_ff;
   logic signed [TWIDDLE_BITS-1:0] wr_ff;
   logic signed [TWIDDLE_BITS-1:0] wi_ff;
   logic       hold_kind_ff;
   logic [WORD_W-1:0] hold_word_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic [WORD_W-1:0] store [MAX_WORDS];
   logic [WORD_W-1:0] rdata_ff;
   logic [TWIDDLE_BITS-1:0] rom_q_ff;
   logic       rom_neg_ff;

   logic [4:0]    bits_clamp;
   logic [4:0]    cb;
   logic [AW:0]   npts;
   logic [AW:0]   n_words;
   logic [AW:0]   n4;
   logic [AW:0]   half;
   logic [AW:0]   i_next;
   logic [AW:0]   k_next;
   logic [AW:0]   j_full;
   logic [AW-2:0] rev_full;
   logic [AW-2:0] rev_q;
   logic [AW-1:0] ang;
   logic [AW-1:0] tw_ang;
   logic [1:0]    quad;
   logic [AW-1:0] rem_q;
   logic [AW-1:0] ridx;
   logic [AW-2:0] rom_addr;
   logic [2:0]    nr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] calc_word;
   logic signed [SUM_W-1:0] wsum;
   logic signed [HALF_W-1:0] edge_v;
   logic signed [HALF_W-1:0] s13;
   logic signed [HALF_W-1:0] d13;
   logic signed [HALF_W-1:0] s24;
   logic signed [HALF_W-1:0] d24;
   logic signed [HALF_W-1:0] h2r;
   logic signed [HALF_W-1:0] h2i;
   logic signed [PROD_W-1:0] pr;
   logic signed [PROD_W-1:0] pi;
   logic          mul_done;
   logic          req_fire;
   logic [AW-1:0] req_addr;

   rfft_cmul #(
      .TWIDDLE_BITS(TWIDDLE_BITS)
   ) u_cmul (
      .clock(clock),
      .reset(reset),
      .start(mul_go_ff),
      .x(x_ff),
      .y(y_ff),
      .wr(wr_ff),
      .wi(wi_ff),
      .done(mul_done),
      .pr(pr),
      .pi(pi)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_addr  = AW'(req_data.word_index);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      bits_clamp = {1'b0, l2w_ff};
      if (bits_clamp < 5'd2) begin
         bits_clamp = 5'd2;
      end else if (bits_clamp > 5'(AW)) begin
         bits_clamp = 5'(AW);
      end
      cb      = bits_ff - 5'd1;
      npts    = (AW+1)'(1) << cb;
      n_words = (AW+1)'(1) << bits_ff;
      n4      = (AW+1)'(1) << (bits_ff - 5'd2);
      half    = (AW+1)'(1) << st_ff;
      i_next  = {1'b0, idx_ff} + (half << 1);
      k_next  = {1'b0, k_ff} + (AW+1)'(1);
      j_full  = {1'b0, idx_ff} + half;
      for (int b = 0; b < AW - 1; b++) begin
         rev_full[b] = idx_ff[AW-2-b];
      end
      rev_q = rev_full >> (5'(AW - 1) - cb);
      if (phase_ff == PH_SPLIT) begin
         ang = k_ff << (5'(AW) - bits_ff);
      end else begin
         ang = k_ff << (5'(AW - 1) - st_ff);
      end
      tw_ang   = (cnt_ff == 3'd0) ? ang : ang + AW'(QUARTER);
      quad     = tw_ang[AW-1 -: 2];
      rem_q    = tw_ang & AW'(QUARTER - 1);
      ridx     = quad[0] ? AW'(QUARTER) - rem_q : rem_q;
      rom_addr = ridx[AW-2:0];
      nr       = (phase_ff == PH_EDGE) ? 3'd2 : 3'd4;
   end

   always_comb begin
      s13 = {w_ff[0][WORD_W-1], w_ff[0]} + {w_ff[2][WORD_W-1], w_ff[2]};
      d13 = {w_ff[0][WORD_W-1], w_ff[0]} - {w_ff[2][WORD_W-1], w_ff[2]};
      s24 = {w_ff[1][WORD_W-1], w_ff[1]} + {w_ff[3][WORD_W-1], w_ff[3]};
      d24 = {w_ff[1][WORD_W-1], w_ff[1]} - {w_ff[3][WORD_W-1], w_ff[3]};
      h2r = s24 >>> 1;
      h2i = d13 >>> 1;
      edge_v = cnt_ff[0] ? {w_ff[0][WORD_W-1], w_ff[0]} - {w_ff[1][WORD_W-1], w_ff[1]}
                         : {w_ff[0][WORD_W-1], w_ff[0]} + {w_ff[1][WORD_W-1], w_ff[1]};
      if (dir_ff) begin
         edge_v = edge_v >>> 1;
      end
      case (cnt_ff[1:0])
         2'd0: wsum = {{5{a_ff[HALF_W-1]}}, a_ff} + {{2{pr[PROD_W-1]}}, pr};
         2'd1: wsum = {{5{b_ff[HALF_W-1]}}, b_ff} + {{2{pi[PROD_W-1]}}, pi};
         2'd2: wsum = {{5{a_ff[HALF_W-1]}}, a_ff} - {{2{pr[PROD_W-1]}}, pr};
         default: begin
            if (phase_ff == PH_BFLY) begin
               wsum = {{5{b_ff[HALF_W-1]}}, b_ff} - {{2{pi[PROD_W-1]}}, pi};
            end else begin
               wsum = {{2{pi[PROD_W-1]}}, pi} - {{5{b_ff[HALF_W-1]}}, b_ff};
            end
         end
      endcase
      case (phase_ff)
         PH_BREV: calc_word = w_ff[cnt_ff[1:0] ^ 2'd2];
         PH_EDGE: calc_word = sat32({{5{edge_v[HALF_W-1]}}, edge_v});
         default: calc_word = sat32(wsum);
      endcase
   end

   always_comb begin
      if (state_ff == S_IDLE) begin
         mem_we    = req_fire && (req_data.op == OP_LOAD);
         mem_waddr = req_addr;
         mem_wdata = {{(WORD_W-SAMPLE_W){req_data.sample_in[SAMPLE_W-1]}},
                      req_data.sample_in};
         mem_raddr = req_addr;
      end else begin
         mem_we    = (state_ff == S_WRITE);
         mem_waddr = addr_ff[cnt_ff[1:0]];
         mem_wdata = calc_word;
         mem_raddr = addr_ff[cnt_ff[1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      rdata_ff   <= store[mem_raddr];
      rom_q_ff   <= SINE_ROM[rom_addr];
      rom_neg_ff <= quad[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dir_ff       <= 1'b0;
         real_ff      <= 1'b1;
         l2w_ff       <= 4'd10;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         cnt_ff       <= 3'd0;
         cfft_done_ff <= 1'b0;
         phase_ff     <= PH_BREV;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIRECTION:  dir_ff  <= csr_data[0];
               CSR_REAL_MODE:  real_ff <= csr_data[0];
               CSR_LOG2_WORDS: l2w_ff  <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         mul_go_ff <= (state_ff == S_PREP);
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_data.op)
                     OP_RUN: begin
                        bits_ff      <= bits_clamp;
                        cfft_done_ff <= 1'b0;
                        state_ff     <= S_START;
                     end
                     OP_READ: state_ff <= S_RDW;
                     default: ;
                  endcase
               end
            end
            S_RDW: begin
               hold_kind_ff <= KIND_DATA;
               hold_word_ff <= rdata_ff;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.result_kind  <= hold_kind_ff;
                  rsp_ff.word_out     <= hold_word_ff;
                  state_ff            <= S_IDLE;
               end
            end
            S_START: begin
               cnt_ff <= 3'd0;
               if (real_ff && (dir_ff || cfft_done_ff)) begin
                  k_ff <= AW'(1);
                  if (n4 > (AW+1)'(1)) begin
                     phase_ff <= PH_SPLIT;
                     state_ff <= S_TWID;
                  end else begin
                     phase_ff   <= PH_EDGE;
                     addr_ff[0] <= AW'(0);
                     addr_ff[1] <= AW'(1);
                     state_ff   <= S_READ;
                  end
               end else begin
                  phase_ff <= PH_BREV;
                  idx_ff   <= '0;
                  state_ff <= S_BREV;
               end
            end
            S_BREV: begin
               cnt_ff <= 3'd0;
               if ({1'b0, rev_q} > idx_ff) begin
                  addr_ff[0] <= {idx_ff[AW-2:0], 1'b0};
                  addr_ff[1] <= {idx_ff[AW-2:0], 1'b1};
                  addr_ff[2] <= {rev_q, 1'b0};
                  addr_ff[3] <= {rev_q, 1'b1};
                  state_ff   <= S_READ;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_TWID: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd1) begin
                  wi_ff <= (rom_neg_ff ^ dir_ff) ? -signed'(rom_q_ff) : signed'(rom_q_ff);
               end
               if (cnt_ff == 3'd2) begin
                  wr_ff    <= rom_neg_ff ? -signed'(rom_q_ff) : signed'(rom_q_ff);
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               cnt_ff <= 3'd0;
               if (phase_ff == PH_SPLIT) begin
                  addr_ff[0] <= {k_ff[AW-2:0], 1'b0};
                  addr_ff[1] <= {k_ff[AW-2:0], 1'b1};
                  addr_ff[2] <= AW'(n_words - {k_ff, 1'b0});
                  addr_ff[3] <= AW'(n_words - {k_ff, 1'b0} + (AW+1)'(1));
               end else begin
                  addr_ff[0] <= {idx_ff[AW-2:0], 1'b0};
                  addr_ff[1] <= {idx_ff[AW-2:0], 1'b1};
                  addr_ff[2] <= {j_full[AW-2:0], 1'b0};
                  addr_ff[3] <= {j_full[AW-2:0], 1'b1};
               end
               state_ff <= S_READ;
            end
            S_READ: begin
               if (cnt_ff != 3'd0) begin
                  w_ff[2'(cnt_ff - 3'd1)] <= rdata_ff;
               end
               if (cnt_ff == nr) begin
                  cnt_ff <= 3'd0;
                  if (phase_ff == PH_BFLY || phase_ff == PH_SPLIT) begin
                     state_ff <= S_PREP;
                  end else begin
                     state_ff <= S_WRITE;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_PREP: begin
               if (phase_ff == PH_BFLY) begin
                  a_ff <= {w_ff[0][WORD_W-1], w_ff[0]};
                  b_ff <= {w_ff[1][WORD_W-1], w_ff[1]};
                  x_ff <= {w_ff[2][WORD_W-1], w_ff[2]};
                  y_ff <= {w_ff[3][WORD_W-1], w_ff[3]};
               end else begin
                  a_ff <= s13 >>> 1;
                  b_ff <= d24 >>> 1;
                  x_ff <= dir_ff ? -h2r : h2r;
                  y_ff <= dir_ff ? h2i : -h2i;
               end
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (mul_done) begin
                  cnt_ff   <= 3'd0;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (cnt_ff == nr - 3'd1) begin
                  cnt_ff   <= 3'd0;
                  state_ff <= S_NEXT;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_NEXT: begin
               cnt_ff <= 3'd0;
               case (phase_ff)
                  PH_BREV: begin
                     if ({1'b0, idx_ff} + (AW+1)'(1) == npts) begin
                        phase_ff <= PH_BFLY;
                        st_ff    <= 5'd0;
                        k_ff     <= '0;
                        idx_ff   <= '0;
                        state_ff <= S_TWID;
                     end else begin
                        idx_ff   <= idx_ff + AW'(1);
                        state_ff <= S_BREV;
                     end
                  end
                  PH_BFLY: begin
                     if (i_next < npts) begin
                        idx_ff   <= AW'(i_next);
                        state_ff <= S_SETUP;
                     end else if (k_next < half) begin
                        k_ff     <= AW'(k_next);
                        idx_ff   <= AW'(k_next);
                        state_ff <= S_TWID;
                     end else if (st_ff + 5'd1 < cb) begin
                        st_ff    <= st_ff + 5'd1;
                        k_ff     <= '0;
                        idx_ff   <= '0;
                        state_ff <= S_TWID;
                     end else if (real_ff && !dir_ff) begin
                        cfft_done_ff <= 1'b1;
                        state_ff     <= S_START;
                     end else begin
                        hold_kind_ff <= KIND_DONE;
                        hold_word_ff <= '0;
                        state_ff     <= S_OUT;
                     end
                  end
                  PH_SPLIT: begin
                     if (k_next < n4) begin
                        k_ff     <= AW'(k_next);
                        state_ff <= S_TWID;
                     end else begin
                        phase_ff   <= PH_EDGE;
                        addr_ff[0] <= AW'(0);
                        addr_ff[1] <= AW'(1);
                        state_ff   <= S_READ;
                     end
                  end
                  default: begin
                     if (dir_ff) begin
                        phase_ff <= PH_BREV;
                        idx_ff   <= '0;
                        state_ff <= S_BREV;
                     end else begin
                        hold_kind_ff <= KIND_DONE;
                        hold_word_ff <= '0;
                        state_ff     <= S_OUT;
                     end
                  end
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.op == OP_RUN) |=> !req_ready)
      else $error("run transaction did not block the request channel");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier finished outside the multiply step");

   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !mem_we)
      else $error("store written while operands are being read");
`endif

endmodule

`default_nettype wire
